[rtl/assert_macros.svh]
// Assertion helpers shared by the checker files.
// Each macro clocks on the rising edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ESPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("esps check failed");

// Next-cycle implication
`define ESPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("esps check failed");

`endif

[rtl/esps_pkg.sv]
// ----------------------------------------------------------------------------
// esps_pkg
// Types and constants for the encoder step phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package esps_pkg;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_1     = 3'd1,
		PH_2     = 3'd2,
		PH_3     = 3'd3,
		PH_4     = 3'd4,
		PH_PAUSE = 3'd5
	} phase_t;

	typedef logic [1:0] func_t;
	localparam func_t FN_TICK  = 2'd0;
	localparam func_t FN_START = 2'd1;
	localparam func_t FN_STOP  = 2'd2;

	localparam int TARGET_W = 16;
	localparam int PAUSE_W  = 16;
	localparam int DUTY_W   = 8;
	localparam int MOVE_W   = 3;
	localparam int STEP_OUT_W = 16;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 5;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_P1_TARGET  = 3'd0;
	localparam reg_idx_t REG_P2_TARGET  = 3'd1;
	localparam reg_idx_t REG_P3_TARGET  = 3'd2;
	localparam reg_idx_t REG_P4_TARGET  = 3'd3;
	localparam reg_idx_t REG_MOVE_COUNT = 3'd4;
	localparam reg_idx_t REG_REPEAT     = 3'd5;
	localparam reg_idx_t REG_PAUSE      = 3'd6;
	localparam reg_idx_t REG_DUTY       = 3'd7;

	localparam logic [TARGET_W-1:0] TARGET_RST = 16'd36;
	localparam logic [PAUSE_W-1:0]  PAUSE_RST  = 16'd1000;
	localparam logic [DUTY_W-1:0]   DUTY_RST   = 8'd100;
	localparam logic [MOVE_W-1:0]   MOVE_RST   = 3'd1;

endpackage

`default_nettype wire

[rtl/esps_cmd_if.sv]
// ----------------------------------------------------------------------------
// esps_cmd_if
// Command channel: func code and sampled encoder level.
// ----------------------------------------------------------------------------
`default_nettype none

interface esps_cmd_if
	import esps_pkg::*;
;
	logic  valid;
	logic  ready;
	func_t func;
	logic  encoder_level;

	modport source (output valid, output func, output encoder_level, input ready);
	modport sink   (input valid, input func, input encoder_level, output ready);
endinterface

`default_nettype wire

[rtl/esps_res_if.sv]
// ----------------------------------------------------------------------------
// esps_res_if
// Result channel: drive state after each command.
// ----------------------------------------------------------------------------
`default_nettype none

interface esps_res_if
	import esps_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic                  motor_on;
	logic                  direction;
	logic [DUTY_W-1:0]     duty_out;
	logic [2:0]            phase;
	logic [STEP_OUT_W-1:0] step_count;

	modport source (output valid, output motor_on, output direction, output duty_out,
		output phase, output step_count, input ready);
	modport sink   (input valid, input motor_on, input direction, input duty_out,
		input phase, input step_count, output ready);
endinterface

`default_nettype wire

[rtl/encoder_step_phase_sequencer.sv]
// ----------------------------------------------------------------------------
// encoder_step_phase_sequencer
// Runs up to four encoder-counted motor phases with alternating direction.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - one transfer per command: tick (with encoder sample), start, stop.
//   res  - one transfer per command, showing motor drive, direction, duty,
//          phase and step count after that command.
//   APB  - eight registers at byte offsets 0x00..0x1C, to be written while idle;
//          the user is bound to this, as the block itself does not enforce it.
// Throughput: one command per cycle unless res stalls; the state is updated in
//   one pass from the input register, so consecutive ticks do not wait.
// A stalled res holds its result; the input register still takes one more
//   command and cmd.ready drops only when both stages are full.
// Reset: phase idle, count and pause cleared, registers back to defaults
//   (targets 36, one movement, repeat off, pause 1000, duty 100).
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_step_phase_sequencer
	import esps_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	esps_cmd_if.sink           cmd,
	esps_res_if.source         res,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [APB_AW-1:0]   paddr,
	input  wire [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	localparam int CMP_W = (COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// configuration
	logic [TARGET_W-1:0] p1_target_q, p2_target_q, p3_target_q, p4_target_q;
	logic [MOVE_W-1:0]   move_count_q;
	logic                repeat_q;
	logic [PAUSE_W-1:0]  pause_ticks_q;
	logic [DUTY_W-1:0]   duty_q;
	logic                wr_en;
	reg_idx_t            wr_idx;

	assign pready = 1'b1;
	assign wr_idx = paddr[APB_AW-1:2];
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_target_q   <= TARGET_RST;
			p2_target_q   <= TARGET_RST;
			p3_target_q   <= TARGET_RST;
			p4_target_q   <= TARGET_RST;
			move_count_q  <= MOVE_RST;
			repeat_q      <= 1'b0;
			pause_ticks_q <= PAUSE_RST;
			duty_q        <= DUTY_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_P1_TARGET:  p1_target_q   <= pwdata[TARGET_W-1:0];
				REG_P2_TARGET:  p2_target_q   <= pwdata[TARGET_W-1:0];
				REG_P3_TARGET:  p3_target_q   <= pwdata[TARGET_W-1:0];
				REG_P4_TARGET:  p4_target_q   <= pwdata[TARGET_W-1:0];
				REG_MOVE_COUNT: move_count_q  <= pwdata[MOVE_W-1:0];
				REG_REPEAT:     repeat_q      <= pwdata[0];
				REG_PAUSE:      pause_ticks_q <= pwdata[PAUSE_W-1:0];
				REG_DUTY:       duty_q        <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (wr_idx)
			REG_P1_TARGET:  prdata = APB_DW'(p1_target_q);
			REG_P2_TARGET:  prdata = APB_DW'(p2_target_q);
			REG_P3_TARGET:  prdata = APB_DW'(p3_target_q);
			REG_P4_TARGET:  prdata = APB_DW'(p4_target_q);
			REG_MOVE_COUNT: prdata = APB_DW'(move_count_q);
			REG_REPEAT:     prdata = APB_DW'(repeat_q);
			REG_PAUSE:      prdata = APB_DW'(pause_ticks_q);
			REG_DUTY:       prdata = APB_DW'(duty_q);
			default:        prdata = '0;
		endcase
	end

	// input register and result register handshake
	logic  valid_s1, res_valid_q, res_free, adv;
	func_t func_s1;
	logic  level_s1;

	assign res_free  = !res_valid_q || res.ready;
	assign adv       = valid_s1 && res_free;
	assign cmd.ready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.ready)
				valid_s1 <= cmd.valid;
			if (res_free)
				res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_s1  <= cmd.func;
			level_s1 <= cmd.encoder_level;
		end
	end

	// sequencer state
	phase_t              phase_q, phase_n;
	logic [COUNT_BITS-1:0] steps_q, steps_n, steps_inc;
	logic [PAUSE_W-1:0]  pause_left_q, pause_left_n;
	logic                last_level_q, last_level_n;
	logic [TARGET_W-1:0] target;
	logic                running_q, running_n;
	logic                edge_seen;

	always_comb begin
		case (phase_q)
			PH_2:    target = p2_target_q;
			PH_3:    target = p3_target_q;
			PH_4:    target = p4_target_q;
			default: target = p1_target_q;
		endcase
	end

	assign running_q = (phase_q != PH_IDLE) && (phase_q != PH_PAUSE);
	assign edge_seen = level_s1 != last_level_q;
	assign steps_inc = (edge_seen && steps_q != COUNT_MAX) ? steps_q + 1'b1 : steps_q;

	always_comb begin
		phase_n      = phase_q;
		steps_n      = steps_q;
		pause_left_n = pause_left_q;
		last_level_n = last_level_q;
		case (func_s1)
			FN_TICK: begin
				last_level_n = level_s1;
				if (running_q) begin
					steps_n = steps_inc;
					if (CMP_W'(steps_inc) >= CMP_W'(target)) begin
						steps_n = '0;
						if (phase_q == PH_4 || logic'(3'(phase_q) == move_count_q)) begin
							if (!repeat_q)
								phase_n = PH_IDLE;
							else if (pause_ticks_q == '0)
								phase_n = PH_1;
							else begin
								phase_n      = PH_PAUSE;
								pause_left_n = pause_ticks_q;
							end
						end else begin
							case (phase_q)
								PH_1:    phase_n = PH_2;
								PH_2:    phase_n = PH_3;
								default: phase_n = PH_4;
							endcase
						end
					end
				end else if (phase_q == PH_PAUSE) begin
					if (pause_left_q <= PAUSE_W'(1)) begin
						pause_left_n = '0;
						phase_n      = PH_1;
						steps_n      = '0;
					end else begin
						pause_left_n = pause_left_q - 1'b1;
					end
				end
			end
			FN_START: begin
				steps_n      = '0;
				pause_left_n = '0;
				phase_n      = PH_1;
			end
			FN_STOP: begin
				steps_n      = '0;
				pause_left_n = '0;
				phase_n      = PH_IDLE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			steps_q      <= '0;
			pause_left_q <= '0;
			last_level_q <= 1'b0;
		end else if (adv) begin
			phase_q      <= phase_n;
			steps_q      <= steps_n;
			pause_left_q <= pause_left_n;
			last_level_q <= last_level_n;
		end
	end

	// result register
	logic                  motor_on_q, direction_q;
	logic [DUTY_W-1:0]     duty_out_q;
	logic [2:0]            phase_out_q;
	logic [STEP_OUT_W-1:0] step_count_q;

	assign running_n = (phase_n != PH_IDLE) && (phase_n != PH_PAUSE);

	always_ff @(posedge clk) begin
		if (adv) begin
			motor_on_q   <= running_n;
			direction_q  <= (phase_n == PH_2) || (phase_n == PH_4);
			duty_out_q   <= running_n ? duty_q : '0;
			phase_out_q  <= 3'(phase_n);
			step_count_q <= STEP_OUT_W'(steps_n);
		end
	end

	assign res.valid      = res_valid_q;
	assign res.motor_on   = motor_on_q;
	assign res.direction  = direction_q;
	assign res.duty_out   = duty_out_q;
	assign res.phase      = phase_out_q;
	assign res.step_count = step_count_q;

endmodule

`default_nettype wire

[rtl/esps_sva.sv]
// ----------------------------------------------------------------------------
// esps_sva
// Port-level checks for the encoder step phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module esps_sva
	import esps_pkg::*;
(
	input wire                  clk,
	input wire                  arst_n,
	input wire                  res_valid,
	input wire                  res_ready,
	input wire                  motor_on,
	input wire                  direction,
	input wire [DUTY_W-1:0]     duty_out,
	input wire [2:0]            phase,
	input wire [STEP_OUT_W-1:0] step_count
);

	// a stalled result stays put
	`ESPS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(phase) && $stable(step_count))

	`ESPS_ASSERT_NOW(a_motor_phase, clk, arst_n, res_valid, motor_on == (phase != 3'(PH_IDLE) && phase != 3'(PH_PAUSE)))

	// stopped motor shows no drive
	`ESPS_ASSERT_NOW(a_stopped_quiet, clk, arst_n, res_valid && !motor_on, duty_out == '0 && !direction)

	// count is cleared whenever no phase runs
	`ESPS_ASSERT_NOW(a_idle_count, clk, arst_n, res_valid && !motor_on, step_count == '0)

endmodule

bind encoder_step_phase_sequencer esps_sva u_esps_sva (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.motor_on   (res.motor_on),
	.direction  (res.direction),
	.duty_out   (res.duty_out),
	.phase      (res.phase),
	.step_count (res.step_count)
);

`default_nettype wire
